>>> hw/rtl/bdr_pkg.sv
// ----------------------------------------------------------------------------
// bdr_pkg
// Shared widths, reset values, register codes, the 8x8 Bayer threshold table
// and the pixel stage type for the Bayer dither RGB332 converter.
// ----------------------------------------------------------------------------
package bdr_pkg;

   // pixel and palette widths
   localparam int PIXEL_W   = 8;
   localparam int PALETTE_W = 8;

   // ordered dither matrix geometry
   localparam int DITHER_SIZE = 8;
   localparam int PHASE_W     = $clog2(DITHER_SIZE);
   localparam int BIAS_W      = 7;

   // configuration registers
   localparam int IMAGE_WIDTH_W = 13;
   localparam int CSR_DATA_W    = IMAGE_WIDTH_W;
   localparam int CSR_INDEX_W   = 1;

   localparam int DEFAULT_MAX_IMAGE_WIDTH = 4096;

   localparam logic                     DITHER_ENABLE_RESET = 1'b1;
   localparam logic [IMAGE_WIDTH_W-1:0] IMAGE_WIDTH_RESET   = 13'd640;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DITHER_ENABLE = 1'b0,
      CSR_IMAGE_WIDTH   = 1'b1
   } csr_index_type;

   // pixel held in the input register with its dither phase
   typedef struct packed {
      logic [PIXEL_W-1:0] red;
      logic [PIXEL_W-1:0] green;
      logic [PIXEL_W-1:0] blue;
      logic [PHASE_W-1:0] col_phase;
      logic [PHASE_W-1:0] row_phase;
   } pixel_stage_type;

   // bayer thresholds, row-major, values 1..64
   localparam logic [BIAS_W-1:0] BAYER_TABLE [DITHER_SIZE*DITHER_SIZE] = '{
      7'd1,  7'd33, 7'd9,  7'd41, 7'd3,  7'd35, 7'd11, 7'd43,
      7'd49, 7'd17, 7'd57, 7'd25, 7'd51, 7'd19, 7'd59, 7'd27,
      7'd13, 7'd45, 7'd5,  7'd37, 7'd15, 7'd47, 7'd7,  7'd39,
      7'd61, 7'd29, 7'd53, 7'd21, 7'd63, 7'd31, 7'd55, 7'd23,
      7'd4,  7'd36, 7'd12, 7'd44, 7'd2,  7'd34, 7'd10, 7'd42,
      7'd52, 7'd20, 7'd60, 7'd28, 7'd50, 7'd18, 7'd58, 7'd26,
      7'd16, 7'd48, 7'd8,  7'd40, 7'd14, 7'd46, 7'd6,  7'd38,
      7'd64, 7'd32, 7'd56, 7'd24, 7'd62, 7'd30, 7'd54, 7'd22
   };

   // threshold lookup by row and column phase
   function automatic logic [BIAS_W-1:0] bayer_bias(input logic [PHASE_W-1:0] row,
                                                    input logic [PHASE_W-1:0] col);
      return BAYER_TABLE[{row, col}];
   endfunction

endpackage

>>> hw/rtl/bdr_front.sv
// ----------------------------------------------------------------------------
// bdr_front
// Input register and raster position tracker: captures each accepted pixel
// with its column and row phase, then advances the scan position.
// ----------------------------------------------------------------------------
module bdr_front
   import bdr_pkg::*;
#(
   parameter int MAX_IMAGE_WIDTH = DEFAULT_MAX_IMAGE_WIDTH
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  logic [PIXEL_W-1:0]       red,
   input  logic [PIXEL_W-1:0]       green,
   input  logic [PIXEL_W-1:0]       blue,
   input  logic                     first_pixel,
   input  logic [IMAGE_WIDTH_W-1:0] image_width,
   output pixel_stage_type          stage
);

   localparam int COL_W = $clog2(MAX_IMAGE_WIDTH);
   localparam int CMP_W = (COL_W + 1 > IMAGE_WIDTH_W) ? COL_W + 1 : IMAGE_WIDTH_W;
   localparam logic [CMP_W-1:0] MAX_WIDTH_C = CMP_W'(MAX_IMAGE_WIDTH);

   logic [COL_W-1:0]   col_ff, col_in, col_cur;
   logic [PHASE_W-1:0] row_ff, row_in, row_cur;
   logic [CMP_W-1:0]   width_ext, width_eff, col_inc;
   pixel_stage_type    stage_ff, stage_in;

   // position of this pixel, restarted by the first-pixel flag
   always_comb begin
      col_cur = first_pixel ? '0 : col_ff;
      row_cur = first_pixel ? '0 : row_ff;
   end

   // advance the scan: wrap to the next row at the end of a line
   always_comb begin
      width_ext = CMP_W'(image_width);
      width_eff = (width_ext > MAX_WIDTH_C) ? MAX_WIDTH_C : width_ext;
      col_inc   = CMP_W'(col_cur) + CMP_W'(1);
      if (col_inc >= width_eff) begin
         col_in = '0;
         row_in = row_cur + PHASE_W'(1);
      end else begin
         col_in = col_inc[COL_W-1:0];
         row_in = row_cur;
      end
   end

   // captured pixel with its dither phase
   always_comb begin
      stage_in.red       = red;
      stage_in.green     = green;
      stage_in.blue      = blue;
      stage_in.col_phase = col_cur[PHASE_W-1:0];
      stage_in.row_phase = row_cur;
   end

   // scan position state
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (accept) begin
         stage_ff <= stage_in;
      end
   end

   assign stage = stage_ff;

endmodule

>>> hw/rtl/bdr_quant.sv
// ----------------------------------------------------------------------------
// bdr_quant
// Adds the Bayer bias to each component, saturates at full scale and packs
// the top bits into an RGB332 palette byte.
// ----------------------------------------------------------------------------
module bdr_quant
   import bdr_pkg::*;
(
   input  pixel_stage_type       stage,
   input  logic                  dither_enable,
   output logic [PALETTE_W-1:0]  palette_index
);

   logic [BIAS_W-1:0]  bias;
   logic [PIXEL_W:0]   red_sum, green_sum, blue_sum;
   logic [PIXEL_W-1:0] red_sat, green_sat, blue_sat;

   // threshold from the matrix, zero when dithering is off
   always_comb begin
      bias = dither_enable ? bayer_bias(stage.row_phase, stage.col_phase) : '0;
   end

   // half bias on red and green, full bias on blue
   always_comb begin
      red_sum   = {1'b0, stage.red}   + (PIXEL_W + 1)'(bias[BIAS_W-1:1]);
      green_sum = {1'b0, stage.green} + (PIXEL_W + 1)'(bias[BIAS_W-1:1]);
      blue_sum  = {1'b0, stage.blue}  + (PIXEL_W + 1)'(bias);
   end

   // clamp to full scale
   always_comb begin
      red_sat   = red_sum[PIXEL_W]   ? '1 : red_sum[PIXEL_W-1:0];
      green_sat = green_sum[PIXEL_W] ? '1 : green_sum[PIXEL_W-1:0];
      blue_sat  = blue_sum[PIXEL_W]  ? '1 : blue_sum[PIXEL_W-1:0];
   end

   // rgb332 packing
   assign palette_index = {red_sat[7:5], green_sat[7:5], blue_sat[7:6]};

endmodule

>>> hw/rtl/bayer_dither_rgb332.sv
// ----------------------------------------------------------------------------
// bayer_dither_rgb332
// An accepted input transaction goes through the input register, then the
// result register, and is presented with rsp_valid. Throughput: one pixel
// per cycle while rsp_stall is low, set by the two-register pipeline.
// Reset clears pipeline valids and the scan position and loads the
// registers with dither on and a 640-pixel line width.
// ----------------------------------------------------------------------------
module bayer_dither_rgb332
   import bdr_pkg::*;
#(
   parameter int MAX_IMAGE_WIDTH = DEFAULT_MAX_IMAGE_WIDTH
) (
   input  logic                   clock,
   input  logic                   reset,
   // configuration port
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   // pixel channel
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [PIXEL_W-1:0]     req_red,
   input  logic [PIXEL_W-1:0]     req_green,
   input  logic [PIXEL_W-1:0]     req_blue,
   input  logic                   req_first_pixel,
   // palette channel
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [PALETTE_W-1:0]   rsp_palette_index
);

   logic                     dither_enable_ff;
   logic [IMAGE_WIDTH_W-1:0] image_width_ff;
   logic                     s1_valid_ff, s1_valid_in;
   logic                     s2_valid_ff, s2_valid_in;
   logic [PALETTE_W-1:0]     palette_ff;
   logic [PALETTE_W-1:0]     palette_in;
   logic                     s2_load;
   logic                     req_accept;
   pixel_stage_type          s1_stage;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         dither_enable_ff <= DITHER_ENABLE_RESET;
         image_width_ff   <= IMAGE_WIDTH_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_DITHER_ENABLE: dither_enable_ff <= csr_wdata[0];
            CSR_IMAGE_WIDTH:   image_width_ff   <= csr_wdata[IMAGE_WIDTH_W-1:0];
            default:           dither_enable_ff <= dither_enable_ff;
         endcase
      end
   end

   // pipeline flow control
   always_comb begin
      s2_load    = !s2_valid_ff || !rsp_stall;
      req_stall  = s1_valid_ff && !s2_load;
      req_accept = req_valid && !req_stall;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s2_load) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      s2_valid_in = s2_load ? s1_valid_ff : s2_valid_ff;
   end

   // input register and scan position
   bdr_front #(
      .MAX_IMAGE_WIDTH(MAX_IMAGE_WIDTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (req_accept),
      .red         (req_red),
      .green       (req_green),
      .blue        (req_blue),
      .first_pixel (req_first_pixel),
      .image_width (image_width_ff),
      .stage       (s1_stage)
   );

   // bias, saturate and pack
   bdr_quant u_quant (
      .stage         (s1_stage),
      .dither_enable (dither_enable_ff),
      .palette_index (palette_in)
   );

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (s2_load && s1_valid_ff) begin
         palette_ff <= palette_in;
      end
   end

   assign rsp_valid         = s2_valid_ff;
   assign rsp_palette_index = palette_ff;

`ifndef SYNTHESIS
   // back pressure only while the input register holds a transaction
   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff)
      else $error("req_stall raised with empty input register");

   // a first pixel always lands at column phase 0, row phase 0
   a_first_pixel_phase: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_first_pixel) |=>
         (s1_stage.col_phase == '0 && s1_stage.row_phase == '0))
      else $error("first pixel captured with nonzero dither phase");

   // a transaction moved out of the input register shows up as a response
   a_stage_to_result: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s2_load) |=> rsp_valid)
      else $error("transaction lost between input and result registers");
`endif

endmodule

>>> bench/bdr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdr_checker
// Watches the pixel, palette and register ports of the Bayer dither RGB332
// converter, keeps its own scan position and register copy, works out the
// palette byte for every accepted pixel and compares it with what comes out.
// ----------------------------------------------------------------------------
module bdr_checker
   import bdr_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  logic [PIXEL_W-1:0]     req_red,
   input  logic [PIXEL_W-1:0]     req_green,
   input  logic [PIXEL_W-1:0]     req_blue,
   input  logic                   req_first_pixel,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  logic [PALETTE_W-1:0]   rsp_palette_index,
   output int                     error_count,
   output int                     pending_count,
   output int                     checked_count
);

   localparam int LINE_LIMIT = DEFAULT_MAX_IMAGE_WIDTH;
   localparam int REPORT_MAX = 10;

   typedef struct {
      logic [PALETTE_W-1:0] palette;
      logic [PIXEL_W-1:0]   red;
      logic [PIXEL_W-1:0]   green;
      logic [PIXEL_W-1:0]   blue;
      logic                 first;
      int                   seq;
   } palette_expect_type;

   palette_expect_type palette_fifo[$];

   // mirrored registers and scan position
   logic                     dither_on;
   logic [IMAGE_WIDTH_W-1:0] line_width;
   logic [11:0]              scan_col;
   logic [PHASE_W-1:0]       scan_row;
   int                       pixel_seq;

   // recursive 8x8 ordered-dither threshold, bits of (row ^ col) and row interleaved
   function automatic logic [BIAS_W-1:0] threshold(input logic [PHASE_W-1:0] row,
                                                   input logic [PHASE_W-1:0] col);
      logic [PHASE_W-1:0] mix;
      mix = row ^ col;
      return {1'b0, mix[0], row[0], mix[1], row[1], mix[2], row[2]} + 7'd1;
   endfunction

   // add the bias, clamp at full scale and keep the top bits
   function automatic logic [PALETTE_W-1:0] quantize(input logic [PIXEL_W-1:0] red,
                                                     input logic [PIXEL_W-1:0] green,
                                                     input logic [PIXEL_W-1:0] blue,
                                                     input logic [BIAS_W-1:0]  bias);
      logic [8:0] r_sum;
      logic [8:0] g_sum;
      logic [8:0] b_sum;
      r_sum = {1'b0, red} + {3'b000, bias[BIAS_W-1:1]};
      g_sum = {1'b0, green} + {3'b000, bias[BIAS_W-1:1]};
      b_sum = {1'b0, blue} + {2'b00, bias};
      if (r_sum > 9'd255) r_sum = 9'd255;
      if (g_sum > 9'd255) g_sum = 9'd255;
      if (b_sum > 9'd255) b_sum = 9'd255;
      return {r_sum[7:5], g_sum[7:5], b_sum[7:6]};
   endfunction

   always @(posedge clock) begin : track
      palette_expect_type entry;
      logic [BIAS_W-1:0]  bias;
      int                 eff_width;
      if (reset) begin
         dither_on     = 1'b1;
         line_width    = 13'd640;
         scan_col      = '0;
         scan_row      = '0;
         pixel_seq     = 0;
         error_count   = 0;
         checked_count = 0;
         palette_fifo.delete();
      end else begin
         // register writes
         if (csr_write_en) begin
            case (csr_index)
               CSR_DITHER_ENABLE: dither_on = csr_wdata[0];
               CSR_IMAGE_WIDTH:   line_width = csr_wdata;
               default: ;
            endcase
         end

         // palette transaction against the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            if (palette_fifo.size() == 0) begin
               if (error_count < REPORT_MAX)
                  $display("unexpected palette transaction %02h with no pixel pending",
                           rsp_palette_index);
               error_count++;
            end else begin
               entry = palette_fifo.pop_front();
               checked_count++;
               if (rsp_palette_index !== entry.palette) begin
                  if (error_count < REPORT_MAX)
                     $display({"palette mismatch on pixel %0d (r=%0d g=%0d b=%0d ",
                               "first=%0b): expected %02h, got %02h"},
                              entry.seq, entry.red, entry.green, entry.blue, entry.first,
                              entry.palette, rsp_palette_index);
                  error_count++;
               end
            end
         end

         // pixel transaction: predict, then advance the scan position
         if (req_valid && !req_stall) begin
            if (req_first_pixel) begin
               scan_col = '0;
               scan_row = '0;
            end
            bias = dither_on ? threshold(scan_row, scan_col[PHASE_W-1:0]) : '0;
            entry.palette = quantize(req_red, req_green, req_blue, bias);
            entry.red     = req_red;
            entry.green   = req_green;
            entry.blue    = req_blue;
            entry.first   = req_first_pixel;
            entry.seq     = pixel_seq;
            palette_fifo.push_back(entry);
            pixel_seq++;
            eff_width = (int'(line_width) > LINE_LIMIT) ? LINE_LIMIT : int'(line_width);
            if (int'(scan_col) + 1 >= eff_width) begin
               scan_col = '0;
               scan_row = scan_row + 1'b1;
            end else begin
               scan_col = scan_col + 1'b1;
            end
         end
      end
      pending_count = palette_fifo.size();
   end

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the Bayer dither RGB332 converter: directed pixels at the
// color extremes and scan corner cases, a short run with the width above
// the line limit, then random frames under changing register settings with
// random idling on both channels and one long sink hold-off. Checking is in
// bdr_checker.
// ----------------------------------------------------------------------------
module tb_top;
   import bdr_pkg::*;

   localparam int     RANDOM_PIXELS = 480;
   localparam int     HOLD_CYCLES   = 64;
   localparam int     SETTLE_CYCLES = 4;
   localparam int     WIDE_PIXELS   = 40;
   localparam longint TIMEOUT_NS    = 3_000_000;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_write_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;
   logic                   req_valid;
   logic                   req_stall;
   logic [PIXEL_W-1:0]     req_red;
   logic [PIXEL_W-1:0]     req_green;
   logic [PIXEL_W-1:0]     req_blue;
   logic                   req_first_pixel;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic [PALETTE_W-1:0]   rsp_palette_index;

   int error_count;
   int pending_count;
   int checked_count;

   // idling controls shared with the sink process
   bit source_idles;
   bit sink_idles;
   int hold_req;
   int hold_done;
   int scan_settings;

   always #5 clock = ~clock;

   bayer_dither_rgb332 DUT (
      .clock             (clock),
      .reset             (reset),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_red           (req_red),
      .req_green         (req_green),
      .req_blue          (req_blue),
      .req_first_pixel   (req_first_pixel),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_palette_index (rsp_palette_index)
   );

   bdr_checker u_checker (.*);

   // mostly short gaps, now and then a long one
   function automatic int gap_length();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 5) return 0;
      if (pick < 8) return $urandom_range(1, 3);
      if (pick < 9) return $urandom_range(4, 8);
      return $urandom_range(10, 40);
   endfunction

   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   // offer one pixel and hold it until the block takes it
   task automatic send_pixel(input logic [7:0] red, input logic [7:0] green,
                             input logic [7:0] blue, input logic first);
      int idle;
      idle = source_idles ? gap_length() : 0;
      repeat (idle) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_red         <= red;
      req_green       <= green;
      req_blue        <= blue;
      req_first_pixel <= first;
      req_valid       <= 1'b1;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_random_pixel(input logic first);
      if ($urandom_range(0, 7) == 0)
         send_pixel(8'($urandom_range(192, 255)), 8'($urandom_range(192, 255)),
                    8'($urandom_range(192, 255)), first);
      else
         send_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)), first);
   endtask

   // stop offering and wait for every palette byte to come back
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // sink side: random stalls, plus a long hold-off on request
   initial begin
      int stall_run;
      rsp_stall = 1'b0;
      stall_run = 0;
      hold_done = 0;
      forever begin
         @(negedge clock);
         if (hold_req != hold_done) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
            hold_done++;
         end else if (stall_run > 0) begin
            rsp_stall <= 1'b1;
            stall_run--;
         end else begin
            rsp_stall <= 1'b0;
            if (sink_idles && $urandom_range(0, 2) == 0) stall_run = gap_length();
         end
      end
   end

   initial begin
      #(TIMEOUT_NS);
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      int random_sent;
      int frame_len;
      bit restart;
      bit first;
      logic dither_bit;
      logic [CSR_DATA_W-1:0] width;

      reset           = 1'b1;
      csr_write_en    = 1'b0;
      csr_index       = CSR_DITHER_ENABLE;
      csr_wdata       = '0;
      req_valid       = 1'b0;
      req_red         = '0;
      req_green       = '0;
      req_blue        = '0;
      req_first_pixel = 1'b0;
      source_idles    = 1'b0;
      sink_idles      = 1'b0;
      hold_req        = 0;
      scan_settings   = 1;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: dither on, 640 wide; color extremes and threshold edges
      send_pixel(8'd0, 8'd0, 8'd0, 1'b1);
      send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
      send_pixel(8'd255, 8'd0, 8'd255, 1'b0);
      send_pixel(8'd0, 8'd255, 8'd0, 1'b0);
      send_pixel(8'd223, 8'd223, 8'd191, 1'b0);
      send_pixel(8'd31, 8'd31, 8'd63, 1'b0);
      send_pixel(8'd128, 8'd64, 8'd200, 1'b1);
      drain();

      // zero width: every pixel ends a row, row phase walks all eight values
      write_csr(CSR_IMAGE_WIDTH, 13'd0);
      for (int i = 0; i < 8; i++) send_pixel(8'd100, 8'd100, 8'd100, i == 0);
      drain();

      // dither off, upper data bits set on the enable write
      write_csr(CSR_DITHER_ENABLE, 13'h1FFE);
      send_pixel(8'd255, 8'd255, 8'd255, 1'b1);
      send_pixel(8'd223, 8'd223, 8'd191, 1'b0);
      drain();

      // width lowered while the column is already past it
      write_csr(CSR_DITHER_ENABLE, 13'h0001);
      write_csr(CSR_IMAGE_WIDTH, 13'd10);
      for (int i = 0; i < 5; i++) send_pixel(8'd90, 8'd150, 8'd30, i == 0);
      drain();
      write_csr(CSR_IMAGE_WIDTH, 13'd3);
      for (int i = 0; i < 3; i++) send_pixel(8'd90, 8'd150, 8'd30, 1'b0);
      drain();
      scan_settings += 3;

      // width beyond the line limit: no early row wrap
      write_csr(CSR_IMAGE_WIDTH, 13'h1FFF);
      for (int i = 0; i < WIDE_PIXELS; i++) send_random_pixel(i == 0);
      drain();
      scan_settings++;

      // random frames under random settings
      random_sent = 0;
      while (random_sent < RANDOM_PIXELS) begin
         dither_bit = 1'($urandom_range(0, 1));
         write_csr(CSR_DITHER_ENABLE, {12'($urandom_range(0, 4095)), dither_bit});
         case ($urandom_range(0, 9))
            0:       width = 13'd0;
            1:       width = 13'd1;
            2, 3:    width = 13'($urandom_range(2, 9));
            4, 5:    width = 13'($urandom_range(10, 40));
            6:       width = 13'd8;
            7:       width = 13'd640;
            8:       width = 13'($urandom_range(0, 8191));
            default: width = 13'd7;
         endcase
         write_csr(CSR_IMAGE_WIDTH, width);
         scan_settings++;

         frame_len    = $urandom_range(16, 64);
         restart      = $urandom_range(0, 3) != 0;
         source_idles = $urandom_range(0, 2) != 0;
         sink_idles   = $urandom_range(0, 2) != 0;

         // one frame with the sink held off while pixels keep coming
         if (scan_settings == 8) begin
            source_idles = 1'b0;
            hold_req++;
         end

         for (int i = 0; i < frame_len; i++) begin
            first = (i == 0 && restart) || ($urandom_range(0, 31) == 0);
            send_random_pixel(first);
         end
         random_sent += frame_len;
         drain();
      end

      source_idles = 1'b0;
      sink_idles   = 1'b0;
      drain();
      repeat (8) @(negedge clock);

      $display("%0d pixels checked over %0d scan settings, widths from 0 to 8191,",
               checked_count, scan_settings);
      $display("dither on and off, random idling on both sides, one %0d-cycle sink hold",
               HOLD_CYCLES);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("%0d palette errors", error_count);
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
